// File: rtl/core/srppt_pkg.sv
// Shared types, constants and codes of the record packet parse and tally block.
package srppt_pkg;

    // Widths of the counters and fields
    localparam int COUNT_BITS      = 20;
    localparam int LENGTH_BITS     = 24;
    localparam int SIZE_LIMIT_BITS = 40;
    localparam int SUM_BITS        = 60;
    localparam int AVG_BITS        = SIZE_LIMIT_BITS + 1;
    localparam int WORD_BITS       = 32;
    localparam int FIELD_BITS      = 64;
    localparam int BIF_BITS        = 4;
    localparam int STATUS_BITS     = 3;

    // Bytes per header word and per record size
    localparam logic [BIF_BITS-1:0] WORD_BYTES = BIF_BITS'(WORD_BITS / 8);
    localparam logic [BIF_BITS-1:0] SIZE_BYTES = BIF_BITS'(FIELD_BITS / 8);

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0]  SIZE_LIMIT = FIELD_BITS'(1) << SIZE_LIMIT_BITS;

    // Divider sequencing
    localparam int DIV_STEPS = SUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Stream and register port widths
    localparam int PAYLOAD_BITS = 2 * COUNT_BITS + SUM_BITS + AVG_BITS;
    localparam int TDATA_BITS   = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int ADDR_BITS    = 4;
    localparam int APB_BITS     = 32;

    // Register indexes
    localparam logic [1:0] REG_MAGIC       = 2'd0;
    localparam logic [1:0] REG_VERSION     = 2'd1;
    localparam logic [1:0] REG_MAX_PACKET  = 2'd2;
    localparam logic [1:0] REG_MAX_RECORDS = 2'd3;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 3'd0,
        ST_TOO_LONG   = 3'd1,
        ST_TRUNCATED  = 3'd2,
        ST_BAD_HEADER = 3'd3,
        ST_TOO_MANY   = 3'd4,
        ST_BAD_FLAG   = 3'd5,
        ST_TRAILING   = 3'd6,
        ST_OVERSIZE   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_COUNT   = 3'd2,
        PH_SIZE    = 3'd3,
        PH_FLAG    = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IN   = 2'd0,
        SQ_DIV  = 2'd1,
        SQ_LOAD = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]   expected_magic;
        logic [WORD_BITS-1:0]   expected_version;
        logic [LENGTH_BITS-1:0] max_packet_bytes;
        logic [COUNT_BITS-1:0]  max_records;
    } cfg_t;

    typedef struct packed {
        status_t               status;
        logic [COUNT_BITS-1:0] record_count;
        logic [COUNT_BITS-1:0] kept_count;
        logic [SUM_BITS-1:0]   total_size;
    } result_t;

endpackage

// File: rtl/core/size_record_packet_parse_tally.sv
// Top level of the record packet parser: stream ports, registers and sequencer.
//
// Bytes of a packet are taken one per cycle on the slave stream while s_tready is high, tlast
// marking the final byte. Once the final byte is taken, s_tready drops: if the packet parsed
// cleanly and holds at least one record, the restoring divider works out the average size
// (one quotient bit per cycle), then the output register is loaded; any other packet goes
// straight to the load. The load waits while an earlier result is still held in the output
// register. The result beat carries the status in tuser; all tallies are zero when
// status is not ok.
module size_record_packet_parse_tally (
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // data_byte
    input  logic                                s_tlast,   // end_of_packet
    // Master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // record_count, kept_count, total_size, average_size, zero fill
    output logic [srppt_pkg::TDATA_BITS-1:0]    m_tdata,
    output logic [srppt_pkg::STATUS_BITS-1:0]   m_tuser,   // status
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srppt_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [srppt_pkg::APB_BITS-1:0]      pwdata,
    output logic [srppt_pkg::APB_BITS-1:0]      prdata,
    output logic                                pready
);
    import srppt_pkg::*;

    seq_state_t              state_reg, state_next;
    cfg_t                    cfg_reg;
    result_t                 final_res;
    result_t                 pend_reg;
    logic                    div_used_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [TDATA_BITS-1:0]   tdata_reg;
    logic [STATUS_BITS-1:0]  tuser_reg;

    logic                    beat;
    logic                    last_beat;
    logic                    div_start;
    logic                    out_load;
    logic                    div_busy;
    logic                    div_done;
    logic [SUM_BITS-1:0]     quotient;
    logic [AVG_BITS-1:0]     avg;
    logic                    cfg_wr;

    assign beat      = s_tvalid && s_tready;
    assign last_beat = beat && s_tlast;
    assign cfg_wr    = psel && penable && pwrite && pready;

    srppt_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat          (beat),
        .data_byte     (s_tdata),
        .end_of_packet (s_tlast),
        .cfg           (cfg_reg),
        .final_res     (final_res)
    );

    srppt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (final_res.total_size),
        .divisor  (final_res.record_count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IN:
            begin
                if (last_beat)
                    state_next = div_start ? SQ_DIV : SQ_LOAD;
            end
            SQ_DIV:
            begin
                if (div_done)
                    state_next = SQ_LOAD;
            end
            SQ_LOAD:
            begin
                if (out_load)
                    state_next = SQ_IN;
            end
            default:
                state_next = SQ_IN;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            SQ_IN:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && s_tlast && (final_res.status == ST_OK) &&
                            (final_res.record_count != '0);
            end
            SQ_DIV:
            begin
            end
            SQ_LOAD:
                out_load = !m_tvalid_reg || m_tready;
            default:
            begin
            end
        endcase
    end

    assign avg = div_used_reg ? quotient[AVG_BITS-1:0] : '0;

    always_comb
    begin
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SQ_IN;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic   <= '0;
            cfg_reg.expected_version <= '0;
            cfg_reg.max_packet_bytes <= {LENGTH_BITS{1'b1}};
            cfg_reg.max_records      <= {COUNT_BITS{1'b1}};
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MAGIC:       cfg_reg.expected_magic   <= pwdata[WORD_BITS-1:0];
                REG_VERSION:     cfg_reg.expected_version <= pwdata[WORD_BITS-1:0];
                REG_MAX_PACKET:  cfg_reg.max_packet_bytes <= pwdata[LENGTH_BITS-1:0];
                REG_MAX_RECORDS: cfg_reg.max_records      <= pwdata[COUNT_BITS-1:0];
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAGIC:       prdata = APB_BITS'(cfg_reg.expected_magic);
            REG_VERSION:     prdata = APB_BITS'(cfg_reg.expected_version);
            REG_MAX_PACKET:  prdata = APB_BITS'(cfg_reg.max_packet_bytes);
            REG_MAX_RECORDS: prdata = APB_BITS'(cfg_reg.max_records);
        endcase
    end

    assign pready = 1'b1;

    // Hold the finished packet's result and load the output beat
    always_ff @(posedge clk)
    begin
        if (last_beat)
        begin
            pend_reg     <= final_res;
            div_used_reg <= div_start;
        end
        if (out_load)
        begin
            tdata_reg <= {{(TDATA_BITS - PAYLOAD_BITS){1'b0}}, avg, pend_reg.total_size,
                          pend_reg.kept_count, pend_reg.record_count};
            tuser_reg <= pend_reg.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    // A failed packet carries no tallies
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("nonzero tallies on a failed packet");

    // The divider only runs while the sequencer waits on it
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == SQ_DIV))
        else $error("divider busy outside the divide state");

    // Input is stalled straight after a final byte
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_beat |=> !s_tready)
        else $error("input ready right after a packet end");

    // The average never exceeds the total
    a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_OK)) |->
        (SUM_BITS'(m_tdata[PAYLOAD_BITS-1:PAYLOAD_BITS-AVG_BITS]) <=
         m_tdata[2*COUNT_BITS+SUM_BITS-1:2*COUNT_BITS]))
        else $error("average size above total size");

endmodule

// File: rtl/core/srppt_parse.sv
// Byte-wise header and record parser with running tallies.
module srppt_parse (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   beat,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_packet,
    input  srppt_pkg::cfg_t        cfg,
    output srppt_pkg::result_t     final_res
);
    import srppt_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [BIF_BITS-1:0]     bif_reg, bif_next;
    logic [FIELD_BITS-1:0]   shift_reg, shift_next;
    logic [COUNT_BITS-1:0]   decl_reg, decl_next;
    logic [COUNT_BITS-1:0]   rec_reg, rec_next;
    logic [COUNT_BITS-1:0]   kept_reg, kept_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [LENGTH_BITS-1:0]  bytes_reg, bytes_next;
    status_t                 err_reg, err_next;
    logic                    over_reg, over_next;

    logic [FIELD_BITS-1:0]   shift_cat;
    logic [BIF_BITS-1:0]     bif_inc;
    logic [BIF_BITS-1:0]     need;
    logic [COUNT_BITS-1:0]   rec_inc;
    logic [WORD_BITS-1:0]    word_val;
    status_t                 status;

    // Work out the state after this byte
    always_comb
    begin
        phase_next = phase_reg;
        bif_next   = bif_reg;
        shift_next = shift_reg;
        decl_next  = decl_reg;
        rec_next   = rec_reg;
        kept_next  = kept_reg;
        sum_next   = sum_reg;
        err_next   = err_reg;
        over_next  = over_reg;
        bytes_next = (bytes_reg != LENGTH_MAX) ? bytes_reg + 1'b1 : bytes_reg;
        shift_cat  = {shift_reg[FIELD_BITS-9:0], data_byte};
        bif_inc    = bif_reg + 1'b1;
        need       = (phase_reg == PH_SIZE) ? SIZE_BYTES : WORD_BYTES;
        rec_inc    = rec_reg + 1'b1;
        word_val   = shift_cat[WORD_BITS-1:0];

        unique case (phase_reg) inside
            PH_ERROR:
            begin
            end
            PH_DONE:
            begin
                err_next   = ST_TRAILING;
                phase_next = PH_ERROR;
            end
            PH_FLAG:
            begin
                if (data_byte > 8'd1)
                begin
                    err_next   = ST_BAD_FLAG;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    kept_next  = kept_reg + COUNT_BITS'(data_byte[0]);
                    rec_next   = rec_inc;
                    phase_next = (rec_inc == decl_reg) ? PH_DONE : PH_SIZE;
                end
            end
            PH_MAGIC, PH_VERSION, PH_COUNT, PH_SIZE:
            begin
                if (bif_inc < need)
                begin
                    shift_next = shift_cat;
                    bif_next   = bif_inc;
                end
                else
                begin
                    // Field complete: check it and move on
                    shift_next = '0;
                    bif_next   = '0;
                    unique case (phase_reg)
                        PH_MAGIC:
                        begin
                            if (word_val != cfg.expected_magic)
                            begin
                                err_next   = ST_BAD_HEADER;
                                phase_next = PH_ERROR;
                            end
                            else
                                phase_next = PH_VERSION;
                        end
                        PH_VERSION:
                        begin
                            if (word_val != cfg.expected_version)
                            begin
                                err_next   = ST_BAD_HEADER;
                                phase_next = PH_ERROR;
                            end
                            else
                                phase_next = PH_COUNT;
                        end
                        PH_COUNT:
                        begin
                            if (word_val > WORD_BITS'(cfg.max_records))
                            begin
                                err_next   = ST_TOO_MANY;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                decl_next  = word_val[COUNT_BITS-1:0];
                                phase_next = (word_val[COUNT_BITS-1:0] == '0) ? PH_DONE
                                                                              : PH_SIZE;
                            end
                        end
                        default:
                        begin
                            if (shift_cat > SIZE_LIMIT)
                                over_next = 1'b1;
                            sum_next   = sum_reg + shift_cat[SUM_BITS-1:0];
                            phase_next = PH_FLAG;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Pick the status in priority order and zero the tallies on failure
    always_comb
    begin
        if (bytes_next > cfg.max_packet_bytes)
            status = ST_TOO_LONG;
        else if (err_next != ST_OK)
            status = err_next;
        else if (phase_next != PH_DONE)
            status = ST_TRUNCATED;
        else if (over_next)
            status = ST_OVERSIZE;
        else
            status = ST_OK;

        final_res.status = status;
        if (status == ST_OK)
        begin
            final_res.record_count = rec_next;
            final_res.kept_count   = kept_next;
            final_res.total_size   = sum_next;
        end
        else
        begin
            final_res.record_count = '0;
            final_res.kept_count   = '0;
            final_res.total_size   = '0;
        end
    end

    // Advance on each beat; clear all packet state after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            bif_reg   <= '0;
            shift_reg <= '0;
            decl_reg  <= '0;
            rec_reg   <= '0;
            kept_reg  <= '0;
            sum_reg   <= '0;
            bytes_reg <= '0;
            err_reg   <= ST_OK;
            over_reg  <= 1'b0;
        end
        else if (beat)
        begin
            if (end_of_packet)
            begin
                phase_reg <= PH_MAGIC;
                bif_reg   <= '0;
                shift_reg <= '0;
                decl_reg  <= '0;
                rec_reg   <= '0;
                kept_reg  <= '0;
                sum_reg   <= '0;
                bytes_reg <= '0;
                err_reg   <= ST_OK;
                over_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                bif_reg   <= bif_next;
                shift_reg <= shift_next;
                decl_reg  <= decl_next;
                rec_reg   <= rec_next;
                kept_reg  <= kept_next;
                sum_reg   <= sum_next;
                bytes_reg <= bytes_next;
                err_reg   <= err_next;
                over_reg  <= over_next;
            end
        end
    end

endmodule

// File: rtl/core/srppt_div.sv
// Restoring divider, one quotient bit per cycle, for the average size.
module srppt_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [srppt_pkg::SUM_BITS-1:0]      dividend,
    input  logic [srppt_pkg::COUNT_BITS-1:0]    divisor,
    output logic                                busy,
    output logic                                done,
    output logic [srppt_pkg::SUM_BITS-1:0]      quotient
);
    import srppt_pkg::*;

    logic                      busy_reg, busy_next;
    logic [DIV_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]     rem_reg, rem_next;
    logic [SUM_BITS-1:0]       quot_reg, quot_next;
    logic [COUNT_BITS-1:0]     dsor_reg, dsor_next;
    logic [COUNT_BITS:0]       trial;

    // One subtract-and-compare step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsor_next = dsor_reg;
        trial     = {rem_reg, quot_reg[SUM_BITS-1]} - {1'b0, dsor_reg};
        done      = busy_reg && (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1));

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = dividend;
            dsor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[COUNT_BITS])
            begin
                rem_next  = trial[COUNT_BITS-1:0];
                quot_next = {quot_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[COUNT_BITS-2:0], quot_reg[SUM_BITS-1]};
                quot_next = {quot_reg[SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (done)
                busy_next = 1'b0;
        end
    end

    // Hold the sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold the working words
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsor_reg <= dsor_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

// File: tb/size_record_packet_parse_tally_tb.sv
// Self-checking testbench of the record packet parser: stimulus, tally prediction, checks.
module size_record_packet_parse_tally_tb;

    import srppt_pkg::*;

    localparam int REC_LO   = 0;
    localparam int KEPT_LO  = COUNT_BITS;
    localparam int TOTAL_LO = 2 * COUNT_BITS;
    localparam int MEAN_LO  = 2 * COUNT_BITS + SUM_BITS;
    localparam int SETTLE   = 80;
    localparam int LIMIT    = 1000000;

    // One expected result beat
    typedef struct {
        status_t                status;
        logic [COUNT_BITS-1:0]  records;
        logic [COUNT_BITS-1:0]  kept;
        logic [SUM_BITS-1:0]    total;
        logic [AVG_BITS-1:0]    mean;
    } packet_tally_t;

    // Tracks the parse of the current packet and holds the tallies still to come
    class tally_checker;
        logic [WORD_BITS-1:0]   magic_want;
        logic [WORD_BITS-1:0]   version_want;
        logic [LENGTH_BITS-1:0] length_cap;
        logic [COUNT_BITS-1:0]  record_cap;
        phase_t                 phase;
        int unsigned            field_pos;
        logic [FIELD_BITS-1:0]  field_acc;
        logic [COUNT_BITS-1:0]  declared;
        logic [COUNT_BITS-1:0]  parsed;
        logic [COUNT_BITS-1:0]  kept;
        logic [SUM_BITS-1:0]    size_total;
        logic [LENGTH_BITS-1:0] byte_count;
        status_t                first_fault;
        bit                     oversize;
        packet_tally_t          tallies_due[$];
        int unsigned            fault_count;
        int unsigned            checked;
        int unsigned            status_seen[8];

        function new();
            magic_want   = '0;
            version_want = '0;
            length_cap   = LENGTH_MAX;
            record_cap   = '1;
            fault_count  = 0;
            checked      = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            clear_packet();
        endfunction

        function void write_reg(logic [1:0] idx, logic [APB_BITS-1:0] val);
            case (idx)
                REG_MAGIC:       magic_want   = val;
                REG_VERSION:     version_want = val;
                REG_MAX_PACKET:  length_cap   = val[LENGTH_BITS-1:0];
                REG_MAX_RECORDS: record_cap   = val[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void clear_packet();
            phase       = PH_MAGIC;
            field_pos   = 0;
            field_acc   = '0;
            declared    = '0;
            parsed      = '0;
            kept        = '0;
            size_total  = '0;
            byte_count  = '0;
            first_fault = ST_OK;
            oversize    = 1'b0;
        endfunction

        function void abort(status_t code);
            first_fault = code;
            phase       = PH_ERROR;
        endfunction

        // Advance the parse by one byte
        function void parse_byte(logic [7:0] b);
            logic [FIELD_BITS-1:0] value;
            int unsigned           need;
            if (phase == PH_ERROR)
                return;
            if (phase == PH_DONE)
            begin
                abort(ST_TRAILING);
                return;
            end
            if (phase == PH_FLAG)
            begin
                if (b > 8'd1)
                begin
                    abort(ST_BAD_FLAG);
                    return;
                end
                kept   = kept + b[0];
                parsed = parsed + 1'b1;
                phase  = (parsed == declared) ? PH_DONE : PH_SIZE;
                return;
            end
            field_acc = {field_acc[FIELD_BITS-9:0], b};
            field_pos++;
            need = (phase == PH_SIZE) ? 8 : 4;
            if (field_pos < need)
                return;
            value     = (need == 4) ? {32'd0, field_acc[WORD_BITS-1:0]} : field_acc;
            field_pos = 0;
            field_acc = '0;
            case (phase)
                PH_MAGIC:
                    if (value[WORD_BITS-1:0] != magic_want) abort(ST_BAD_HEADER);
                    else phase = PH_VERSION;
                PH_VERSION:
                    if (value[WORD_BITS-1:0] != version_want) abort(ST_BAD_HEADER);
                    else phase = PH_COUNT;
                PH_COUNT:
                    if (value > FIELD_BITS'(record_cap))
                        abort(ST_TOO_MANY);
                    else
                    begin
                        declared = value[COUNT_BITS-1:0];
                        phase    = (declared == '0) ? PH_DONE : PH_SIZE;
                    end
                default:
                begin
                    if (value > SIZE_LIMIT)
                        oversize = 1'b1;
                    size_total = size_total + value[SUM_BITS-1:0];
                    phase      = PH_FLAG;
                end
            endcase
        endfunction

        // Note an accepted input beat; the final byte of a packet yields one tally
        function void take_beat(logic [7:0] b, logic last);
            packet_tally_t t;
            if (byte_count != LENGTH_MAX)
                byte_count++;
            parse_byte(b);
            if (!last)
                return;
            if (byte_count > length_cap)       t.status = ST_TOO_LONG;
            else if (first_fault != ST_OK)     t.status = first_fault;
            else if (phase != PH_DONE)         t.status = ST_TRUNCATED;
            else if (oversize)                 t.status = ST_OVERSIZE;
            else                               t.status = ST_OK;
            t.records = '0;
            t.kept    = '0;
            t.total   = '0;
            t.mean    = '0;
            if (t.status == ST_OK)
            begin
                t.records = parsed;
                t.kept    = kept;
                t.total   = size_total;
                if (parsed != '0)
                    t.mean = AVG_BITS'(size_total / SUM_BITS'(parsed));
            end
            tallies_due.insert(tallies_due.size(), t);
            clear_packet();
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
                fault_count++;
            end
        endfunction

        // Check an accepted result beat against the oldest tally due
        function void check_beat(logic [TDATA_BITS-1:0] data, logic [STATUS_BITS-1:0] user);
            packet_tally_t t;
            if (tallies_due.size() == 0)
            begin
                $display("%0t: result beat with status %0d arrived with none outstanding",
                         $time, user);
                fault_count++;
                return;
            end
            t = tallies_due.pop_front();
            checked++;
            status_seen[t.status]++;
            compare("status", t.status, user);
            compare("record_count", t.records, data[REC_LO +: COUNT_BITS]);
            compare("kept_count", t.kept, data[KEPT_LO +: COUNT_BITS]);
            compare("total_size", t.total, data[TOTAL_LO +: SUM_BITS]);
            compare("average_size", t.mean, data[MEAN_LO +: AVG_BITS]);
        endfunction

        function int unsigned outstanding();
            return tallies_due.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [TDATA_BITS-1:0]   m_tdata;
    logic [STATUS_BITS-1:0]  m_tuser;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_BITS-1:0]    paddr;
    logic [APB_BITS-1:0]     pwdata;
    logic [APB_BITS-1:0]     prdata;
    logic                    pready;

    tally_checker            sb;
    logic [7:0]              pkt[$];
    int unsigned             bytes_sent;
    int unsigned             packets_sent;
    int unsigned             cycles;
    bit                      calm;

    size_record_packet_parse_tally DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles", $time, cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones; none in calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Append one byte to the packet being built
    function automatic void add_byte(logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endfunction

    function automatic void put_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            add_byte(w[8*i +: 8]);
    endfunction

    function automatic void put_size(logic [63:0] w);
        for (int i = 7; i >= 0; i--)
            add_byte(w[8*i +: 8]);
    endfunction

    // Record sizes: mostly within the limit, with the edges around it
    function automatic logic [63:0] pick_size();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 31))
            0:       return 64'd0;
            1:       return SIZE_LIMIT;
            2:       return SIZE_LIMIT + 64'd1;
            3:       return '1;
            4:       return w;
            default: return (w & (SIZE_LIMIT - 64'd1)) >> $urandom_range(0, 39);
        endcase
    endfunction

    // Build one packet: mostly well formed, the rest broken or noise
    function automatic void build_packet();
        int unsigned       kind;
        int unsigned       n;
        int unsigned       cut;
        int unsigned       bitpos;
        int                bad_flag_at;
        int                big_at;
        logic [31:0]       magic;
        logic [31:0]       version;
        logic [31:0]       count_field;
        logic [63:0]       rec_size;
        pkt.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 94)
        begin
            repeat ($urandom_range(1, 24))
                add_byte(8'($urandom));
            return;
        end
        magic       = sb.magic_want;
        version     = sb.version_want;
        n           = $urandom_range(0, (sb.record_cap < 4) ? sb.record_cap : 4);
        count_field = n;
        bad_flag_at = -1;
        big_at      = -1;
        bitpos      = $urandom_range(0, 31);
        if (kind >= 70 && kind < 76)
        begin
            if ($urandom_range(0, 1) == 0)
                magic[bitpos] = ~magic[bitpos];
            else
                version[bitpos] = ~version[bitpos];
        end
        else if (kind >= 76 && kind < 82)
        begin
            count_field = ($urandom_range(0, 3) == 0) ? $urandom
                                                      : sb.record_cap + $urandom_range(1, 3);
            n = $urandom_range(0, 1);
        end
        else if (kind >= 82 && kind < 88 && n > 0)
            bad_flag_at = $urandom_range(0, n - 1);
        else if (kind >= 88 && n > 0)
            big_at = $urandom_range(0, n - 1);
        put_word(magic);
        put_word(version);
        put_word(count_field);
        for (int r = 0; r < n; r++)
        begin
            if (r == big_at)
                rec_size = ($urandom_range(0, 1) == 0) ? SIZE_LIMIT + 64'd1
                                                       : {$urandom, $urandom} | (SIZE_LIMIT << 1);
            else
                rec_size = pick_size();
            put_size(rec_size);
            if (r == bad_flag_at)
                add_byte(8'($urandom_range(2, 255)));
            else
                add_byte(8'($urandom_range(0, 1)));
        end
        // Cut short or pad out
        if (kind >= 55 && kind < 63 && pkt.size() > 1)
        begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
        if (kind >= 63 && kind < 70)
            repeat ($urandom_range(1, 3))
                add_byte(8'($urandom));
    endfunction

    // Offer one beat and hold it until taken
    task automatic send_beat(logic [7:0] b, logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_beat(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_beat(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // Hold the sender until every tally has come back, then let the block settle
    task automatic drain(int unsigned settle);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [APB_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic configure(logic [31:0] m, logic [31:0] v, logic [23:0] len,
                             logic [19:0] recs);
        drain(SETTLE);
        set_reg(REG_MAGIC, m);
        set_reg(REG_VERSION, v);
        set_reg(REG_MAX_PACKET, {8'd0, len});
        set_reg(REG_MAX_RECORDS, {12'd0, recs});
    endtask

    task automatic run_phase(logic [31:0] m, logic [31:0] v, logic [23:0] len,
                             logic [19:0] recs, bit quiet, int unsigned budget);
        int unsigned target;
        configure(m, v, len, recs);
        calm   = quiet;
        target = bytes_sent + budget;
        while (bytes_sent < target)
        begin
            build_packet();
            send_packet();
            if ($urandom_range(0, 19) == 0)
                drain(1);
        end
    endtask

    // Result side: sample at the edge, then pick the ready for the next cycle
    initial
    begin
        int unsigned stall;
        stall = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser);
            if (stall != 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        sb           = new();
        bytes_sent   = 0;
        packets_sent = 0;
        calm         = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone byte, wrong magic, bare header, then length limit of zero
        pkt.delete();
        add_byte(8'h5A);
        send_packet();
        pkt.delete();
        repeat (4) add_byte(8'hFF);
        send_packet();
        pkt.delete();
        repeat (12) add_byte(8'h00);
        send_packet();
        configure(32'd0, 32'd0, 24'd0, 20'hFFFFF);
        pkt.delete();
        add_byte(8'h80);
        send_packet();

        // Random phases over several register settings, extremes included
        run_phase($urandom, $urandom, 24'hFFFFFF, 20'hFFFFF, 1'b0, 230);
        run_phase(32'hFFFFFFFF, 32'h0, 24'd40, 20'd3, 1'b0, 200);
        run_phase($urandom, 32'hFFFFFFFF, 24'($urandom_range(20, 120)), 20'd0, 1'b1, 120);
        run_phase($urandom, $urandom, 24'hFFFFFF, 20'($urandom_range(1, 6)), 1'b0, 280);

        drain(SETTLE);
        $display("Covered %0d packets in %0d bytes over six register settings,",
                 packets_sent, bytes_sent);
        $display("  %0d tallies checked", sb.checked);
        $display("Statuses: ok %0d, too long %0d, truncated %0d, bad header %0d, too many %0d,",
                 sb.status_seen[ST_OK], sb.status_seen[ST_TOO_LONG],
                 sb.status_seen[ST_TRUNCATED], sb.status_seen[ST_BAD_HEADER],
                 sb.status_seen[ST_TOO_MANY]);
        $display("  bad flag %0d, trailing %0d, oversize %0d",
                 sb.status_seen[ST_BAD_FLAG], sb.status_seen[ST_TRAILING],
                 sb.status_seen[ST_OVERSIZE]);
        if (sb.fault_count == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/srppt_pkg.sv
rtl/core/srppt_parse.sv
rtl/core/srppt_div.sv
rtl/core/size_record_packet_parse_tally.sv
tb/size_record_packet_parse_tally_tb.sv
